FILE: rtl/gpsp_pkg.sv
// Shared types, codes and command tables for the game pad serial poll master.
package gpsp_pkg;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_POLL  = 2'd1;
  localparam logic [1:0] MODE_SETUP = 2'd2;

  localparam logic [1:0] FRAME_POLL = 2'd3;
  localparam logic [1:0] FRAME_LAST_SETUP = 2'd2;
  localparam logic [3:0] LAST_BYTE = 4'd8;

  localparam logic [0:0] CFG_RUMBLE = 1'd0;
  localparam logic [0:0] CFG_GAP    = 1'd1;

  typedef struct packed {
    logic [1:0] mode;
    logic       dat_in;
  } gpsp_in_t;

  typedef struct packed {
    logic       sel_out;
    logic       clk_out;
    logic       cmd_out;
    logic       done_res;
    logic [7:0] pad_id;
    logic [7:0] check_byte;
    logic [7:0] buttons_low;
    logic [7:0] buttons_high;
    logic [7:0] right_x;
    logic [7:0] right_y;
    logic [7:0] left_x;
    logic [7:0] left_y;
  } gpsp_out_t;

  // Command byte sent at a given frame and byte position.
  function automatic logic [7:0] cmd_byte(input logic [1:0] frame_n,
                                          input logic [3:0] byte_idx,
                                          input logic [7:0] rumble);
    logic [7:0] b;
    b = 8'h00;
    case (frame_n)
      FRAME_POLL: begin
        case (byte_idx)
          4'd0: b = 8'h01;
          4'd1: b = 8'h42;
          4'd3: b = (rumble != 8'h00) ? 8'h01 : 8'h00;
          4'd4: b = rumble;
          default: b = 8'h00;
        endcase
      end
      2'd0: begin
        case (byte_idx)
          4'd0: b = 8'h01;
          4'd1: b = 8'h43;
          4'd3: b = 8'h01;
          default: b = 8'h00;
        endcase
      end
      2'd1: begin
        case (byte_idx)
          4'd0: b = 8'h01;
          4'd1: b = 8'h44;
          4'd3: b = 8'h01;
          4'd4: b = 8'h03;
          default: b = 8'h00;
        endcase
      end
      default: begin
        case (byte_idx) inside
          4'd0: b = 8'h01;
          4'd1: b = 8'h4D;
          4'd4: b = 8'h01;
          [4'd5:4'd8]: b = 8'hFF;
          default: b = 8'h00;
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/gpsp_stream_if.sv
// Valid/ready stream channel carrying one item of payload type T.
interface gpsp_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/game_pad_serial_poll_master.sv
// Game pad serial poll master: one tick per item, result register on the output.
// The result for an item is valid the cycle after the item is accepted.
// Throughput: one item per cycle; the single result register refills on the
//   cycle it is taken, so input ready only drops while a result waits unread.
// Reset: rst is synchronous; the frame sequencer returns to idle, rumble_level
//   clears and gap_ticks loads 2.
module game_pad_serial_poll_master
  import gpsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  gpsp_stream_if.sink   tick,
  gpsp_stream_if.source result,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_LOW     = 3'd1;
  localparam logic [2:0] PH_HIGH    = 3'd2;
  localparam logic [2:0] PH_GAP     = 3'd3;
  localparam logic [2:0] PH_BETWEEN = 3'd4;

  logic [7:0] rumble_level;
  logic [7:0] gap_ticks;

  logic [2:0] phase, phase_next;
  logic [1:0] frame_num, frame_next;
  logic [3:0] byte_idx, byte_next;
  logic [2:0] bit_idx, bit_next;
  logic [7:0] gap_count, gap_next;
  logic [7:0] receive_shift, shift_next;
  logic [7:0] reply_bytes [7];
  logic       reply_we;
  logic [2:0] reply_slot;

  gpsp_out_t  res, res_next;
  logic       res_valid;
  logic       acc;

  logic [2:0] ph;
  logic [1:0] fr;
  logic [3:0] by;
  logic [2:0] bi;
  logic [7:0] cmd_val;

  assign tick.ready   = !res_valid || result.ready;
  assign acc          = tick.valid && tick.ready;
  assign result.valid = res_valid;
  assign result.data  = res;
  assign reply_slot   = 3'(byte_idx - 4'd1);

  always_comb begin
    ph = phase;
    fr = frame_num;
    by = byte_idx;
    bi = bit_idx;
    // a start in idle is also the first tick of the first bit
    if (ph == PH_IDLE && (tick.data.mode == MODE_POLL || tick.data.mode == MODE_SETUP)) begin
      fr = (tick.data.mode == MODE_POLL) ? FRAME_POLL : 2'd0;
      by = 4'd0;
      bi = 3'd0;
      ph = PH_LOW;
    end
    cmd_val = cmd_byte(fr, by, rumble_level);

    phase_next = ph;
    frame_next = fr;
    byte_next  = by;
    bit_next   = bi;
    gap_next   = gap_count;
    shift_next = receive_shift;
    reply_we   = 1'b0;
    res_next   = '0;
    res_next.sel_out = 1'b1;
    res_next.clk_out = 1'b1;
    res_next.cmd_out = 1'b1;

    unique case (ph)
      PH_IDLE: begin
        phase_next = PH_IDLE;
      end
      PH_LOW: begin
        res_next.sel_out = 1'b0;
        res_next.clk_out = 1'b0;
        res_next.cmd_out = cmd_val[bi];
        shift_next[bi]   = tick.data.dat_in;
        phase_next       = PH_HIGH;
      end
      PH_HIGH: begin
        res_next.sel_out = 1'b0;
        res_next.cmd_out = cmd_val[bi];
        if (bi != 3'd7) begin
          bit_next   = bi + 3'd1;
          phase_next = PH_LOW;
        end else begin
          reply_we   = (by >= 4'd1) && (by <= 4'd7);
          gap_next   = (gap_ticks == 8'd0) ? 8'd1 : gap_ticks;
          phase_next = PH_GAP;
        end
      end
      PH_GAP: begin
        res_next.sel_out = 1'b0;
        if (gap_count > 8'd1) begin
          gap_next = gap_count - 8'd1;
        end else begin
          gap_next = 8'd0;
          if (by < LAST_BYTE) begin
            byte_next  = by + 4'd1;
            bit_next   = 3'd0;
            phase_next = PH_LOW;
          end else if (fr == FRAME_POLL) begin
            res_next.done_res     = 1'b1;
            res_next.pad_id       = reply_bytes[0];
            res_next.check_byte   = reply_bytes[1];
            res_next.buttons_low  = ~reply_bytes[2];
            res_next.buttons_high = ~reply_bytes[3];
            res_next.right_x      = reply_bytes[4];
            res_next.right_y      = reply_bytes[5];
            res_next.left_x       = reply_bytes[6];
            res_next.left_y       = receive_shift;
            phase_next            = PH_IDLE;
          end else if (fr < FRAME_LAST_SETUP) begin
            phase_next = PH_BETWEEN;
          end else begin
            phase_next = PH_IDLE;
          end
        end
      end
      PH_BETWEEN: begin
        frame_next = fr + 2'd1;
        byte_next  = 4'd0;
        bit_next   = 3'd0;
        phase_next = PH_LOW;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rumble_level <= 8'd0;
      gap_ticks    <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RUMBLE: rumble_level <= cfg_data;
        CFG_GAP:    gap_ticks    <= cfg_data;
        default:    gap_ticks    <= gap_ticks;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      frame_num <= 2'd0;
      byte_idx  <= 4'd0;
      bit_idx   <= 3'd0;
      gap_count <= 8'd0;
    end else if (acc) begin
      phase     <= phase_next;
      frame_num <= frame_next;
      byte_idx  <= byte_next;
      bit_idx   <= bit_next;
      gap_count <= gap_next;
    end
  end

  // capture the reply byte at the end of each of bytes 1 to 7
  always_ff @(posedge clk) begin
    if (acc) begin
      receive_shift <= shift_next;
      if (reply_we) begin
        reply_bytes[reply_slot] <= receive_shift;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (acc) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res <= res_next;
    end
  end

`ifndef ASSERT_OFF
  a_low_then_high: assert property (@(posedge clk) disable iff (rst)
    acc && phase == PH_LOW |=> phase == PH_HIGH)
    else $error("bit low tick not followed by high tick");

  a_done_from_gap: assert property (@(posedge clk) disable iff (rst)
    acc && phase != PH_GAP |=> !res.done_res)
    else $error("frame done outside the gap phase");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> tick.ready)
    else $error("input stalled with empty result register");

  a_done_sel_low: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.done_res |-> !res.sel_out && res.cmd_out)
    else $error("done item without select low and command idle");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the game pad serial poll master: ticks in, line levels out.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gpsp_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int FILL_RANDOM = 0;
  localparam int FILL_ONES = 1;
  localparam int FILL_ZEROS = 2;
  localparam int PHASE_ITEMS = 20;
  localparam int CYCLE_LIMIT = 400000;

  // Set-up frames back to back: enter config, analog mode, rumble map.
  localparam logic [0:26][7:0] SETUP_CMDS = {
    8'h01, 8'h43, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h01, 8'h44, 8'h00, 8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h01, 8'h4D, 8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF
  };

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_BIT_LOW, SEQ_BIT_HIGH, SEQ_GAP, SEQ_BETWEEN
  } seq_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = CFG_RUMBLE;
  logic [7:0] cfg_data = 8'h00;

  gpsp_stream_if #(.T(gpsp_in_t)) tick_ch ();
  gpsp_stream_if #(.T(gpsp_out_t)) result_ch ();

  game_pad_serial_poll_master uut (
    .clk(clk),
    .rst(rst),
    .tick(tick_ch),
    .result(result_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Mirror of the sequencer and its registers.
  seq_phase_t seq_ph = SEQ_IDLE;
  logic [1:0] frame_q = 2'd0;
  logic [3:0] byte_q = 4'd0;
  logic [2:0] bit_q = 3'd0;
  logic [7:0] gap_left = 8'd0;
  logic [7:0] rx_byte = 8'd0;
  logic [7:0] reply_q [0:6];
  logic [7:0] rumble_reg = 8'd0;
  logic [7:0] gap_reg = 8'd2;

  gpsp_in_t pending_ticks[$];
  gpsp_out_t expected_lines[$];
  gpsp_out_t oldest_line;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int cycle_count = 0;

  always #4 clk = ~clk;

  function automatic logic [7:0] tx_byte();
    if (frame_q == FRAME_POLL) begin
      case (byte_q)
        4'd0: return 8'h01;
        4'd1: return 8'h42;
        4'd3: return (rumble_reg != 8'd0) ? 8'h01 : 8'h00;
        4'd4: return rumble_reg;
        default: return 8'h00;
      endcase
    end
    if (byte_q <= LAST_BYTE)
      return SETUP_CMDS[int'(frame_q) * 9 + int'(byte_q)];
    return 8'h00;
  endfunction

  // Advance the mirror by one tick and return the line levels it drives.
  function automatic gpsp_out_t pad_line_step(gpsp_in_t it);
    gpsp_out_t r;
    logic [7:0] cmd_now;
    r = '0;
    r.sel_out = 1'b1;
    r.clk_out = 1'b1;
    r.cmd_out = 1'b1;
    if (seq_ph == SEQ_IDLE && (it.mode == MODE_POLL || it.mode == MODE_SETUP)) begin
      frame_q = (it.mode == MODE_POLL) ? FRAME_POLL : 2'd0;
      byte_q = 4'd0;
      bit_q = 3'd0;
      seq_ph = SEQ_BIT_LOW;
    end
    cmd_now = tx_byte();
    case (seq_ph)
      SEQ_BIT_LOW: begin
        r.sel_out = 1'b0;
        r.clk_out = 1'b0;
        r.cmd_out = cmd_now[bit_q];
        rx_byte[bit_q] = it.dat_in;
        seq_ph = SEQ_BIT_HIGH;
      end
      SEQ_BIT_HIGH: begin
        r.sel_out = 1'b0;
        r.cmd_out = cmd_now[bit_q];
        if (bit_q != 3'd7) begin
          bit_q = bit_q + 3'd1;
          seq_ph = SEQ_BIT_LOW;
        end else begin
          if (byte_q >= 4'd1 && byte_q <= 4'd7)
            reply_q[3'(byte_q - 4'd1)] = rx_byte;
          gap_left = (gap_reg != 8'd0) ? gap_reg : 8'd1;
          seq_ph = SEQ_GAP;
        end
      end
      SEQ_GAP: begin
        r.sel_out = 1'b0;
        if (gap_left > 8'd1) begin
          gap_left = gap_left - 8'd1;
        end else begin
          gap_left = 8'd0;
          if (byte_q < LAST_BYTE) begin
            byte_q = byte_q + 4'd1;
            bit_q = 3'd0;
            seq_ph = SEQ_BIT_LOW;
          end else if (frame_q == FRAME_POLL) begin
            r.done_res = 1'b1;
            r.pad_id = reply_q[0];
            r.check_byte = reply_q[1];
            r.buttons_low = ~reply_q[2];
            r.buttons_high = ~reply_q[3];
            r.right_x = reply_q[4];
            r.right_y = reply_q[5];
            r.left_x = reply_q[6];
            r.left_y = rx_byte;
            seq_ph = SEQ_IDLE;
          end else if (frame_q < FRAME_LAST_SETUP) begin
            seq_ph = SEQ_BETWEEN;
          end else begin
            seq_ph = SEQ_IDLE;
          end
        end
      end
      SEQ_BETWEEN: begin
        frame_q = frame_q + 2'd1;
        byte_q = 4'd0;
        bit_q = 3'd0;
        seq_ph = SEQ_BIT_LOW;
      end
      default: seq_ph = SEQ_IDLE;
    endcase
    return r;
  endfunction

  // Driver: present the next pending item once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      tick_ch.valid <= 1'b0;
    end else begin
      if (tick_ch.valid && tick_ch.ready)
        expected_lines.push_back(pad_line_step(tick_ch.data));
      if (!tick_ch.valid || tick_ch.ready) begin
        if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          tick_ch.valid <= 1'b1;
          tick_ch.data <= pending_ticks.pop_front();
        end else begin
          tick_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %02h actual %02h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_lines.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time,
                   result_ch.data);
          mismatches++;
        end else begin
          oldest_line = expected_lines.pop_front();
          check_field("sel_out", 8'(oldest_line.sel_out), 8'(result_ch.data.sel_out));
          check_field("clk_out", 8'(oldest_line.clk_out), 8'(result_ch.data.clk_out));
          check_field("cmd_out", 8'(oldest_line.cmd_out), 8'(result_ch.data.cmd_out));
          check_field("done_res", 8'(oldest_line.done_res),
                      8'(result_ch.data.done_res));
          check_field("pad_id", oldest_line.pad_id, result_ch.data.pad_id);
          check_field("check_byte", oldest_line.check_byte, result_ch.data.check_byte);
          check_field("buttons_low", oldest_line.buttons_low, result_ch.data.buttons_low);
          check_field("buttons_high", oldest_line.buttons_high,
                      result_ch.data.buttons_high);
          check_field("right_x", oldest_line.right_x, result_ch.data.right_x);
          check_field("right_y", oldest_line.right_y, result_ch.data.right_y);
          check_field("left_x", oldest_line.left_x, result_ch.data.left_x);
          check_field("left_y", oldest_line.left_y, result_ch.data.left_y);
        end
      end
      result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_tick(input logic [1:0] m, input logic d);
    gpsp_in_t t;
    t.mode = m;
    t.dat_in = d;
    pending_ticks.push_back(t);
  endtask

  function automatic int poll_len();
    return 9 * (16 + ((gap_reg == 8'd0) ? 1 : int'(gap_reg)));
  endfunction

  function automatic int setup_len();
    return 3 * poll_len() + 2;
  endfunction

  // Queue a start followed by plain ticks; noisy frames carry ignored starts.
  task automatic queue_frame(input logic [1:0] start_mode, input int fill,
                             input int len, input bit noisy);
    logic [1:0] m;
    logic d;
    for (int i = 0; i < len; i++) begin
      m = (i == 0) ? start_mode : MODE_TICK;
      if (i != 0 && noisy && $urandom_range(0, 9) == 0)
        m = 2'($urandom_range(0, 3));
      case (fill)
        FILL_ONES: d = 1'b1;
        FILL_ZEROS: d = 1'b0;
        default: d = 1'($urandom_range(0, 1));
      endcase
      push_tick(m, d);
    end
  endtask

  task automatic queue_random_sequence(output int n);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      n = poll_len();
      queue_frame(MODE_POLL, FILL_RANDOM, n, 1'($urandom_range(0, 1)));
    end else if (pick < 68) begin
      n = setup_len();
      queue_frame(MODE_SETUP, FILL_RANDOM, n, 1'($urandom_range(0, 1)));
    end else if (pick < 85) begin
      // cut the frame short: the next start lands mid-frame
      n = $urandom_range(1, poll_len() - 1);
      queue_frame(MODE_POLL, FILL_RANDOM, n, 1'b1);
    end else begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        push_tick(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Drain all items and results, then pad with plain ticks until the
  // sequencer is back in idle.
  task automatic settle_idle();
    forever begin
      @(negedge clk);
      while (pending_ticks.size() != 0 || tick_ch.valid || expected_lines.size() != 0)
        @(negedge clk);
      if (seq_ph == SEQ_IDLE)
        break;
      for (int i = 0; i < 16; i++)
        push_tick(MODE_TICK, 1'($urandom_range(0, 1)));
    end
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_RUMBLE)
      rumble_reg = val;
    else
      gap_reg = val;
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [7:0] rumble, input logic [7:0] gap,
                           input int send_pct, input int recv_pct);
    int queued;
    int n;
    write_reg(CFG_RUMBLE, rumble);
    write_reg(CFG_GAP, gap);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    queued = 0;
    while (queued < PHASE_ITEMS) begin
      queue_random_sequence(n);
      queued += n;
    end
    settle_idle();
  endtask

  initial begin
    for (int i = 0; i < 7; i++)
      reply_q[i] = 8'd0;
    tick_ch.valid = 1'b0;
    tick_ch.data = '0;
    result_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle ticks incl. the spare mode, full-scale replies, set-up.
    push_tick(MODE_TICK, 1'b0);
    push_tick(MODE_SPARE, 1'b1);
    push_tick(MODE_TICK, 1'b1);
    push_tick(MODE_SPARE, 1'b0);
    queue_frame(MODE_POLL, FILL_ONES, poll_len(), 1'b0);
    queue_frame(MODE_POLL, FILL_ZEROS, poll_len(), 1'b0);
    queue_frame(MODE_SETUP, FILL_RANDOM, setup_len(), 1'b1);
    settle_idle();

    run_phase(8'hFF, 8'd1, 0, 0);
    run_phase(8'($urandom_range(1, 254)), 8'd0, 66, 0);
    run_phase(8'h00, 8'd3, 0, 66);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(1, 6)), 38, 38);

    // Wide gap: one frame only.
    write_reg(CFG_RUMBLE, 8'h01);
    write_reg(CFG_GAP, 8'd8);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_frame(MODE_POLL, FILL_RANDOM, poll_len(), 1'b1);
    settle_idle();

    repeat (4) @(posedge clk);
    if (expected_lines.size() != 0) begin
      $display("%0t: results missing, expected %0d more actual 0", $time,
               expected_lines.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
